// File: sv/vqor_pkg.sv
// Shared types, constants and register codes of the vote qualified on/off ramp controller.
package vqor_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int MAX_RESULTS = 64;
	localparam logic [9:0] LEVEL_MAX = 10'd1023;

	localparam logic [2:0] REG_ROUNDS    = 3'd0;
	localparam logic [2:0] REG_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_MIN_VOTES = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_TOP       = 3'd4;

	typedef struct packed {
		logic [4:0]  rounds_per_decision;
		logic [11:0] sample_threshold;
		logic [2:0]  min_votes;
		logic [9:0]  ramp_step;
		logic [3:0]  ramp_top_steps;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rounds_per_decision: 5'd3,
		sample_threshold:    12'd50,
		min_votes:           3'd5,
		ramp_step:           10'd100,
		ramp_top_steps:      4'd7
	};

	typedef enum logic [1:0] {
		DEC_OFF,
		DEC_STEADY,
		DEC_RAMP
	} dec_kind_t;

	typedef struct packed {
		logic      valid;
		dec_kind_t kind;
	} dec_t;

	typedef enum logic {
		EM_IDLE,
		EM_RUN
	} emit_state_t;

endpackage

// File: sv/vqor_lane.sv
// One voting lane: compares a single sensor sample with the threshold and registers the vote.
module vqor_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [vqor_pkg::SAMPLE_W-1:0] sample,
	input  logic [vqor_pkg::SAMPLE_W-1:0] threshold,
	output logic                          vote_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			vote_s1 <= (sample <= threshold);
		end
	end

endmodule

// File: sv/vqor_merge.sv
// Merging stage: counts the lane votes of one round and decides whether the round passed.
module vqor_merge #(
	parameter int FINGERS = 5
) (
	input  logic [FINGERS-1:0] votes,
	input  logic [2:0]         min_votes,
	output logic               pass
);

	localparam int VW = $clog2(FINGERS + 1);
	localparam int CW = (VW > 3) ? VW : 3;

	logic [VW-1:0] count;

	always_comb begin
		count = '0;
		for (int k = 0; k < FINGERS; k++) begin
			count = count + VW'(votes[k]);
		end
		pass = (CW'(count) >= CW'(min_votes));
	end

endmodule

// File: sv/vqor_emit.sv
// Write sequencer: turns one decision into actuator writes behind a registered output stage.
module vqor_emit #(
	parameter int FINGERS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vqor_pkg::cfg_t cfg,
	input  vqor_pkg::dec_t dec,
	output logic           dec_take,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,   // dac_channel [2:0], dac_value [12:3], zero [15:13]
	output logic           m_tuser,   // decision_on
	output logic           m_tlast    // last_write
);

	localparam int LW      = (FINGERS > 1) ? $clog2(FINGERS) : 1;
	localparam int TOP_CAP = vqor_pkg::MAX_RESULTS / FINGERS - 1;

	vqor_pkg::emit_state_t state_q, state_d;

	logic [LW-1:0] lane_q;
	logic [3:0]    step_q;
	logic [9:0]    lvl_q;
	logic          ramp_q;
	logic          on_q;
	logic          m_tvalid_q;
	logic [2:0]    chan_out_q;
	logic [9:0]    val_out_q;
	logic          on_out_q;
	logic          last_out_q;

	logic [3:0]  top;
	logic [13:0] prod;
	logic [9:0]  steady_lvl;
	logic [10:0] sum;
	logic [9:0]  ramp_next;
	logic [3:0]  chan_wide;
	logic        lane_last;
	logic        last_w;
	logic        out_adv;
	logic        gen;

	always_comb begin
		if (int'(cfg.ramp_top_steps) > TOP_CAP) begin
			top = 4'(TOP_CAP);
		end else begin
			top = cfg.ramp_top_steps;
		end
		prod       = {10'b0, top} * {4'b0, cfg.ramp_step};
		steady_lvl = (prod > {4'b0, vqor_pkg::LEVEL_MAX}) ? vqor_pkg::LEVEL_MAX : prod[9:0];
		sum        = {1'b0, lvl_q} + {1'b0, cfg.ramp_step};
		ramp_next  = sum[10] ? vqor_pkg::LEVEL_MAX : sum[9:0];
		chan_wide  = 4'(lane_q) + 4'd1;
		lane_last  = (lane_q == LW'(FINGERS - 1));
		last_w     = lane_last && (!ramp_q || (step_q == top));
		out_adv    = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vqor_pkg::EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		dec_take = 1'b0;
		gen      = 1'b0;
		unique case (state_q)
			vqor_pkg::EM_IDLE: begin
				if (dec.valid) begin
					dec_take = 1'b1;
					state_d  = vqor_pkg::EM_RUN;
				end
			end
			vqor_pkg::EM_RUN: begin
				if (out_adv) begin
					gen = 1'b1;
					if (last_w) begin
						state_d = vqor_pkg::EM_IDLE;
					end
				end
			end
			default: begin
				state_d = vqor_pkg::EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dec_take) begin
			lane_q <= '0;
			step_q <= '0;
			ramp_q <= (dec.kind == vqor_pkg::DEC_RAMP);
			on_q   <= (dec.kind != vqor_pkg::DEC_OFF);
			lvl_q  <= (dec.kind == vqor_pkg::DEC_STEADY) ? steady_lvl : 10'd0;
		end else if (gen) begin
			if (lane_last) begin
				lane_q <= '0;
				if (ramp_q && (step_q != top)) begin
					step_q <= step_q + 4'd1;
					lvl_q  <= ramp_next;
				end
			end else begin
				lane_q <= lane_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_adv) begin
			m_tvalid_q <= gen;
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			chan_out_q <= chan_wide[2:0];
			val_out_q  <= lvl_q;
			on_out_q   <= on_q;
			last_out_q <= last_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, val_out_q, chan_out_q};
	assign m_tuser  = on_out_q;
	assign m_tlast  = last_out_q;

endmodule

// File: sv/vote_qualified_onoff_ramp.sv
// A round is registered by the lanes, then merged and counted once no pending decision blocks it;
// the first write of a closing round passes the decision register, the sequencer load and the
// registered output stage. Throughput: one round per cycle while no decision waits; a decision
// holds the sequencer for a load plus FINGERS writes, or FINGERS times (top + 1) for a ramp;
// a later decision waits in the decision register while it is busy, and the rounds behind it stall.
// Reset: arst_n clears the round count, the on flag and all valid flags at once; the
// configuration registers return to their default values.
module vote_qualified_onoff_ramp #(
	parameter int MAX_ROUNDS = 16,
	parameter int FINGERS    = 5
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  logic [2:0]                                       cfg_index,
	input  logic [11:0]                                      cfg_wdata,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	// sample_0 .. sample_(FINGERS-1), 12 bits each from the lowest bit up, zero fill
	input  logic [((FINGERS*vqor_pkg::SAMPLE_W+7)/8)*8-1:0] s_tdata,
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	output logic [15:0]                                      m_tdata, // dac_channel, dac_value
	output logic                                             m_tuser, // decision_on
	output logic                                             m_tlast  // last_write
);

	localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

	vqor_pkg::cfg_t cfg_q;
	vqor_pkg::dec_t dec_q;

	logic [FINGERS-1:0] vote_s1;
	logic               valid_s1;
	logic               pass;
	logic               s_accept;
	logic               s1_adv;
	logic               dec_take;
	logic               dec_push;
	logic [CNT_W-1:0]   round_count_q;
	logic [CNT_W-1:0]   cnt_next;
	logic               all_passed_q;
	logic               ramped_q;
	logic               ap_next;
	logic [LIM_W-1:0]   lim_raw;
	logic [LIM_W-1:0]   limit;
	logic               close;
	vqor_pkg::dec_kind_t kind_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= vqor_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vqor_pkg::REG_ROUNDS:    cfg_q.rounds_per_decision <= cfg_wdata[4:0];
				vqor_pkg::REG_THRESHOLD: cfg_q.sample_threshold    <= cfg_wdata;
				vqor_pkg::REG_MIN_VOTES: cfg_q.min_votes           <= cfg_wdata[2:0];
				vqor_pkg::REG_STEP:      cfg_q.ramp_step           <= cfg_wdata[9:0];
				vqor_pkg::REG_TOP:       cfg_q.ramp_top_steps      <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	assign s1_adv   = valid_s1 && (!dec_q.valid || dec_take);
	assign s_tready = !valid_s1 || s1_adv;
	assign s_accept = s_tvalid && s_tready;

	for (genvar g = 0; g < FINGERS; g++) begin : g_lane
		vqor_lane u_lane (
			.clk       (clk),
			.en        (s_accept),
			.sample    (s_tdata[g*vqor_pkg::SAMPLE_W +: vqor_pkg::SAMPLE_W]),
			.threshold (cfg_q.sample_threshold),
			.vote_s1   (vote_s1[g])
		);
	end

	vqor_merge #(
		.FINGERS (FINGERS)
	) u_merge (
		.votes     (vote_s1),
		.min_votes (cfg_q.min_votes),
		.pass      (pass)
	);

	always_comb begin
		lim_raw = LIM_W'(cfg_q.rounds_per_decision);
		priority if (lim_raw == '0) begin
			limit = LIM_W'(1);
		end else if (lim_raw > LIM_W'(MAX_ROUNDS)) begin
			limit = LIM_W'(MAX_ROUNDS);
		end else begin
			limit = lim_raw;
		end
		cnt_next = round_count_q + CNT_W'(1);
		close    = (LIM_W'(cnt_next) >= limit);
		ap_next  = all_passed_q && pass;
		priority if (!ap_next) begin
			kind_next = vqor_pkg::DEC_OFF;
		end else if (ramped_q) begin
			kind_next = vqor_pkg::DEC_STEADY;
		end else begin
			kind_next = vqor_pkg::DEC_RAMP;
		end
		dec_push = s1_adv && close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			round_count_q <= '0;
			all_passed_q  <= 1'b1;
			ramped_q      <= 1'b0;
			dec_q         <= '{valid: 1'b0, kind: vqor_pkg::DEC_OFF};
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !s1_adv);
			if (s1_adv) begin
				if (close) begin
					round_count_q <= '0;
					all_passed_q  <= 1'b1;
					ramped_q      <= ap_next;
				end else begin
					round_count_q <= cnt_next;
					all_passed_q  <= ap_next;
				end
			end
			if (dec_push) begin
				dec_q <= '{valid: 1'b1, kind: kind_next};
			end else if (dec_take) begin
				dec_q.valid <= 1'b0;
			end
		end
	end

	vqor_emit #(
		.FINGERS (FINGERS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.dec      (dec_q),
		.dec_take (dec_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		round_count_q < CNT_W'(MAX_ROUNDS))
		else $error("round count reached the round limit without closing a decision");

	a_ramp_once: assert property (@(posedge clk) disable iff (!arst_n)
		dec_push && (kind_next == vqor_pkg::DEC_RAMP) |-> !ramped_q)
		else $error("ramp issued while the output was already on");

	a_decision_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dec_push |=> all_passed_q && (round_count_q == '0) && dec_q.valid)
		else $error("decision closed without restarting the round state");

	a_pending_kept: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.valid && !dec_take |=> dec_q.valid && $stable(dec_q.kind))
		else $error("pending decision lost before the sequencer took it");

endmodule
